// ----- rtl/hts_pkg.sv -----
// Package for the hysteresis thermostat: payload structs, event codes,
// register indexes, reset values and the front-to-back bundle type.
// No dependencies; every module of the block imports it.
package hts_pkg;

  localparam int unsigned MaxEvents = 3;
  localparam int unsigned EvIdxW    = $clog2(MaxEvents + 1);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_HYST_BAND  = 3'd1,
    REG_ALARM_HIGH = 3'd2,
    REG_MIN_ON     = 3'd3,
    REG_MIN_OFF    = 3'd4,
    REG_TIMEOUT    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EV_SENSOR_LOST      = 3'd0,
    EV_SENSOR_RECOVERED = 3'd1,
    EV_OVER_TEMPERATURE = 3'd2,
    EV_OUTPUT_ON        = 3'd3,
    EV_OUTPUT_OFF       = 3'd4
  } event_kind_e;

  localparam logic signed [15:0] SetpointRst = 16'sd320;
  localparam logic [14:0]        BandRst     = 15'd16;
  localparam logic signed [15:0] AlarmRst    = 16'sd1280;
  localparam logic [31:0]        MinOnRst    = 32'd0;
  localparam logic [31:0]        MinOffRst   = 32'd0;
  localparam logic [31:0]        TimeoutRst  = 32'd5000;

  typedef struct packed {
    logic              sample_ok;
    logic signed [15:0] temperature;
    logic [31:0]       timestamp_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic signed [15:0] event_temperature;
    logic [31:0]        event_time;
    logic               heater_level;
    logic [31:0]        switches_done;
    logic               last_event;
  } out_t;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic [14:0]        hysteresis_band;
    logic signed [15:0] alarm_high;
    logic [31:0]        min_on_ms;
    logic [31:0]        min_off_ms;
    logic [31:0]        sensor_timeout_ms;
  } cfg_t;

  // One event slot: kind, heater level after it, and whether it follows the
  // switch of this sample (selects the post-switch count).
  typedef struct packed {
    event_kind_e kind;
    logic        heater;
    logic        post;
  } ev_slot_t;

  typedef struct packed {
    logic [EvIdxW-1:0]            n;
    ev_slot_t [MaxEvents-1:0]     ev;
    logic signed [15:0]           temperature;
    logic [31:0]                  time_ms;
    logic [31:0]                  cnt_pre;
    logic [31:0]                  cnt_post;
  } bundle_t;

endpackage

// ----- rtl/hysteresis_thermostat_with_dwell.sv -----
// Top level of the hysteresis thermostat with dwell times.
// Depends on hts_pkg, hts_front, hts_queue and hts_back.
//
// Use: present one sample per request on the input channel (sample_ok,
// temperature in signed 1/16 degree, millisecond timestamp). Each sample
// yields zero to three event results on the output channel, the final one
// marked by last_event. The configuration channel writes one register per
// request (index 0..5); it is always ready, and writes to other indexes are
// dropped. Write configuration only while the block is idle.
// Path: a sample accepted by the front is written to the bundle queue, then
// loaded into the back's current-bundle register, which presents its first event.
// Throughput: the front takes a sample every cycle while the bundle queue
// has room; the back delivers one event per cycle while the receiver is
// ready, so a sample holds the single result port for each of its events
// (at most three), while silent samples never reach it.
// Reset: heater off, all latches clear, switch count zero, registers at
// their defaults; no clearing pass is needed.
// Receiver stall: the back holds its current event, the queue fills, and
// input ready drops only once the queue is full.
module hysteresis_thermostat_with_dwell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hts_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hts_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hts_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hts_pkg::*;

  cfg_t    cfg_q;
  logic    q_push, q_pop, q_full, q_valid;
  bundle_t q_wdata, q_rdata;

  // Configuration registers: keep only the low bits of each register width.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint          <= SetpointRst;
      cfg_q.hysteresis_band   <= BandRst;
      cfg_q.alarm_high        <= AlarmRst;
      cfg_q.min_on_ms         <= MinOnRst;
      cfg_q.min_off_ms        <= MinOffRst;
      cfg_q.sensor_timeout_ms <= TimeoutRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SETPOINT:   cfg_q.setpoint          <= cfg_data_i[15:0];
        REG_HYST_BAND:  cfg_q.hysteresis_band   <= cfg_data_i[14:0];
        REG_ALARM_HIGH: cfg_q.alarm_high        <= cfg_data_i[15:0];
        REG_MIN_ON:     cfg_q.min_on_ms         <= cfg_data_i;
        REG_MIN_OFF:    cfg_q.min_off_ms        <= cfg_data_i;
        REG_TIMEOUT:    cfg_q.sensor_timeout_ms <= cfg_data_i;
        default:        cfg_q                   <= cfg_q;
      endcase
    end
  end

  // Front: classify the sample and advance the control state.
  hts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (q_push),
    .bundle_o   (q_wdata),
    .q_full_i   (q_full)
  );

  // Queue: decouple the sample side from a stalled result side.
  hts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // Back: serialise each bundle into individual event results.
  hts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_on_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_kind == EV_OUTPUT_ON)) |-> out_data_o.heater_level)
    else $error("output-on event with heater low");
  a_off_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_kind == EV_OUTPUT_OFF)) |-> !out_data_o.heater_level)
    else $error("output-off event with heater high");
  a_lost_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_kind == EV_SENSOR_LOST)) |-> !out_data_o.heater_level)
    else $error("sensor-lost event with heater still on");
`endif

endmodule

// ----- rtl/hts_front.sv -----
// Front part: accepts samples, runs the thermostat decision combinationally,
// registers the state update on acceptance, and emits one event bundle per sample that causes events.
// Depends on hts_pkg.
module hts_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hts_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hts_pkg::in_t    in_data_i,
  output logic            push_o,
  output hts_pkg::bundle_t bundle_o,
  input  logic            q_full_i
);
  import hts_pkg::*;

  logic        heater_q, heater_d;
  logic        lost_q, lost_d;
  logic        latch_q, latch_d;
  logic        ever_valid_q, ever_valid_d;
  logic        ever_sw_q, ever_sw_d;
  logic [31:0] last_valid_q, last_valid_d;
  logic [31:0] last_sw_q, last_sw_d;
  logic [31:0] count_q, count_d;

  logic signed [16:0] t_x, sp_x, al_x, half_x, band_x;
  logic signed [16:0] on_thr, off_thr, rel_thr;
  logic [31:0]        el_sw, el_valid;
  logic               on_dwell_ok, off_dwell_ok;
  logic               accept;
  logic               sw;
  logic [EvIdxW-1:0]  n;
  ev_slot_t [MaxEvents-1:0] ev;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign t_x     = {in_data_i.temperature[15], in_data_i.temperature};
  assign sp_x    = {cfg_i.setpoint[15], cfg_i.setpoint};
  assign al_x    = {cfg_i.alarm_high[15], cfg_i.alarm_high};
  assign half_x  = {3'b000, cfg_i.hysteresis_band[14:1]};
  assign band_x  = {2'b00, cfg_i.hysteresis_band};
  assign on_thr  = sp_x - half_x;
  assign off_thr = sp_x + half_x;
  assign rel_thr = al_x - band_x;

  assign el_sw    = in_data_i.timestamp_ms - last_sw_q;
  assign el_valid = in_data_i.timestamp_ms - last_valid_q;
  assign on_dwell_ok  = !ever_sw_q || (el_sw >= cfg_i.min_off_ms);
  assign off_dwell_ok = !ever_sw_q || (el_sw >= cfg_i.min_on_ms);

  always_comb begin
    heater_d     = heater_q;
    lost_d       = lost_q;
    latch_d      = latch_q;
    ever_valid_d = ever_valid_q;
    sw           = 1'b0;
    n            = '0;
    for (int i = 0; i < MaxEvents; i++) begin
      ev[i] = '{kind: EV_SENSOR_LOST, heater: 1'b0, post: 1'b0};
    end
    last_valid_d = last_valid_q;

    if (!in_data_i.sample_ok) begin
      if (ever_valid_q && (el_valid >= cfg_i.sensor_timeout_ms) && !lost_q) begin
        lost_d = 1'b1;
        // safety stop: dwell does not hold back this switch off
        if (heater_q) begin
          heater_d = 1'b0;
          sw       = 1'b1;
          ev[n]    = '{kind: EV_OUTPUT_OFF, heater: 1'b0, post: 1'b1};
          n        = n + 1'b1;
        end
        ev[n] = '{kind: EV_SENSOR_LOST, heater: 1'b0, post: sw};
        n     = n + 1'b1;
      end
    end else begin
      if (lost_q) begin
        lost_d = 1'b0;
        ev[n]  = '{kind: EV_SENSOR_RECOVERED, heater: heater_q, post: 1'b0};
        n      = n + 1'b1;
      end
      last_valid_d = in_data_i.timestamp_ms;
      ever_valid_d = 1'b1;
      if (t_x >= al_x) begin
        if (!latch_q) begin
          latch_d = 1'b1;
          ev[n]   = '{kind: EV_OVER_TEMPERATURE, heater: heater_q, post: 1'b0};
          n       = n + 1'b1;
        end
        if (heater_q) begin
          heater_d = 1'b0;
          sw       = 1'b1;
          ev[n]    = '{kind: EV_OUTPUT_OFF, heater: 1'b0, post: 1'b1};
          n        = n + 1'b1;
        end
      end else begin
        latch_d = latch_q && !(t_x < rel_thr);
        if (!latch_d) begin
          if (!heater_q && (t_x <= on_thr)) begin
            if (on_dwell_ok) begin
              heater_d = 1'b1;
              sw       = 1'b1;
              ev[n]    = '{kind: EV_OUTPUT_ON, heater: 1'b1, post: 1'b1};
              n        = n + 1'b1;
            end
          end else if (heater_q && (t_x >= off_thr)) begin
            if (off_dwell_ok) begin
              heater_d = 1'b0;
              sw       = 1'b1;
              ev[n]    = '{kind: EV_OUTPUT_OFF, heater: 1'b0, post: 1'b1};
              n        = n + 1'b1;
            end
          end
        end
      end
    end

    ever_sw_d = ever_sw_q || sw;
    last_sw_d = sw ? in_data_i.timestamp_ms : last_sw_q;
    count_d   = sw ? count_q + 32'd1 : count_q;
  end

  assign push_o               = accept && (n != '0);
  assign bundle_o.n           = n;
  assign bundle_o.ev          = ev;
  assign bundle_o.temperature = in_data_i.temperature;
  assign bundle_o.time_ms     = in_data_i.timestamp_ms;
  assign bundle_o.cnt_pre     = count_q;
  assign bundle_o.cnt_post    = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q     <= 1'b0;
      lost_q       <= 1'b0;
      latch_q      <= 1'b0;
      ever_valid_q <= 1'b0;
      ever_sw_q    <= 1'b0;
      last_valid_q <= '0;
      last_sw_q    <= '0;
      count_q      <= '0;
    end else if (accept) begin
      heater_q     <= heater_d;
      lost_q       <= lost_d;
      latch_q      <= latch_d;
      ever_valid_q <= ever_valid_d;
      ever_sw_q    <= ever_sw_d;
      last_valid_q <= last_valid_d;
      last_sw_q    <= last_sw_d;
      count_q      <= count_d;
    end
  end

endmodule

// ----- rtl/hts_queue.sv -----
// Short queue of event bundles between the front and back parts.
// Depends on hts_pkg (bundle_t, QDepth and pointer widths).
module hts_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hts_pkg::bundle_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output hts_pkg::bundle_t rdata_o
);
  import hts_pkg::*;

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCntW'(QDepth)))
    else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a write");
`endif

endmodule

// ----- rtl/hts_back.sv -----
// Back part: takes one event bundle at a time and delivers its events one
// per cycle on the result channel while it is ready. Depends on hts_pkg.
module hts_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  hts_pkg::bundle_t q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hts_pkg::out_t    out_data_o
);
  import hts_pkg::*;

  bundle_t           cur_q;
  logic [EvIdxW-1:0] idx_q;
  logic              busy_q;
  logic              last;
  logic              taken;
  ev_slot_t          slot;

  assign slot  = cur_q.ev[idx_q];
  assign last  = (idx_q == cur_q.n - 1'b1);
  assign taken = busy_q && out_ready_i;
  assign pop_o = q_valid_i && (!busy_q || (taken && last));

  assign out_valid_o                  = busy_q;
  assign out_data_o.event_kind        = slot.kind;
  assign out_data_o.event_temperature = cur_q.temperature;
  assign out_data_o.event_time        = cur_q.time_ms;
  assign out_data_o.heater_level      = slot.heater;
  assign out_data_o.switches_done     = slot.post ? cur_q.cnt_post : cur_q.cnt_pre;
  assign out_data_o.last_event        = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (taken) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

// ----- bench/hysteresis_thermostat_with_dwell_tb.sv -----
// Self-checking bench for hysteresis_thermostat_with_dwell: directed and random
// temperature samples, a scoreboard that predicts every event result.
// Depends on hts_pkg and the hysteresis_thermostat_with_dwell RTL only.
module hysteresis_thermostat_with_dwell_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hts_pkg::*;

  // Register indexes outside the map; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 45;
  // Two-deep bundle queue and back stage, with margin.
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 200000;

  // Predicts the event results of each sample and holds them until they
  // come out of the block, oldest first.
  class thermostat_scoreboard;
    localparam int unsigned MaxReported = 60;

    logic signed [15:0] setpoint;
    logic [14:0]        band;
    logic signed [15:0] alarm;
    logic [31:0]        min_on;
    logic [31:0]        min_off;
    logic [31:0]        timeout;

    bit          heater;
    bit          sensor_lost;
    bit          latched;
    bit          seen_valid;
    bit          switched;
    logic [31:0] last_valid_ms;
    logic [31:0] last_switch_ms;
    logic [31:0] switch_count;

    logic signed [15:0] cur_temp;
    logic [31:0]        cur_ms;
    out_t               step_events[$];
    out_t               expected_events[$];
    int unsigned        fails;

    function new();
      setpoint       = SetpointRst;
      band           = BandRst;
      alarm          = AlarmRst;
      min_on         = MinOnRst;
      min_off        = MinOffRst;
      timeout        = TimeoutRst;
      heater         = 1'b0;
      sensor_lost    = 1'b0;
      latched        = 1'b0;
      seen_valid     = 1'b0;
      switched       = 1'b0;
      last_valid_ms  = '0;
      last_switch_ms = '0;
      switch_count   = '0;
      fails          = 0;
    endfunction

    function void report(string msg);
      fails++;
      if (fails <= MaxReported) $display("%0t ns MISMATCH %s", $time, msg);
    endfunction

    // Keep only the low bits of the register width; drop unknown indexes.
    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        REG_SETPOINT:   setpoint = d[15:0];
        REG_HYST_BAND:  band     = d[14:0];
        REG_ALARM_HIGH: alarm    = d[15:0];
        REG_MIN_ON:     min_on   = d;
        REG_MIN_OFF:    min_off  = d;
        REG_TIMEOUT:    timeout  = d;
        default: ;
      endcase
    endfunction

    function void emit(event_kind_e kind);
      out_t e;
      e.event_kind        = kind;
      e.event_temperature = cur_temp;
      e.event_time        = cur_ms;
      e.heater_level      = heater;
      e.switches_done     = switch_count;
      e.last_event        = 1'b0;
      step_events.push_back(e);
    endfunction

    function void switch_heater(bit on);
      heater = on;
      switch_count++;
      switched = 1'b1;
      last_switch_ms = cur_ms;
      if (on) emit(EV_OUTPUT_ON);
      else emit(EV_OUTPUT_OFF);
    endfunction

    // Honour the dwell times, except that a safety stop cuts the run short.
    function void ask_heater(bit on);
      logic [31:0] elapsed;
      if (heater == on) return;
      elapsed = cur_ms - last_switch_ms;
      if (on) begin
        if (switched && elapsed < min_off) return;
      end else if (switched && elapsed < min_on && !sensor_lost && !latched) begin
        return;
      end
      switch_heater(on);
    endfunction

    function void note_sample(in_t s);
      int   t;
      int   sp;
      int   al;
      int   bw;
      out_t e;
      step_events.delete();
      cur_temp = s.temperature;
      cur_ms   = s.timestamp_ms;
      t  = $signed(s.temperature);
      sp = $signed(setpoint);
      al = $signed(alarm);
      bw = band;
      if (!s.sample_ok) begin
        if (seen_valid && (cur_ms - last_valid_ms) >= timeout && !sensor_lost) begin
          sensor_lost = 1'b1;
          ask_heater(1'b0);
          emit(EV_SENSOR_LOST);
        end
      end else begin
        if (sensor_lost) begin
          sensor_lost = 1'b0;
          emit(EV_SENSOR_RECOVERED);
        end
        last_valid_ms = cur_ms;
        seen_valid = 1'b1;
        if (t >= al) begin
          if (!latched) begin
            latched = 1'b1;
            emit(EV_OVER_TEMPERATURE);
          end
          if (heater) switch_heater(1'b0);
        end else begin
          if (latched && t < al - bw) latched = 1'b0;
          if (!latched) begin
            if (!heater && t <= sp - (bw >>> 1)) ask_heater(1'b1);
            else if (heater && t >= sp + (bw >>> 1)) ask_heater(1'b0);
          end
        end
      end
      if (step_events.size() > 0) begin
        e = step_events.pop_back();
        e.last_event = 1'b1;
        step_events.push_back(e);
      end
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
    endfunction

    function void check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endfunction

    function void check_event(out_t got);
      out_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d, time 0x%0h",
                         got.event_kind, got.event_time));
        return;
      end
      want = expected_events.pop_front();
      check_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
      check_field("event_temperature", {16'd0, got.event_temperature},
                  {16'd0, want.event_temperature});
      check_field("event_time", got.event_time, want.event_time);
      check_field("heater_level", 32'(got.heater_level), 32'(want.heater_level));
      check_field("switches_done", got.switches_done, want.switches_done);
      check_field("last_event", 32'(got.last_event), 32'(want.last_event));
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  thermostat_scoreboard sb;
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct     = 0;
  int unsigned          cycle_count   = 0;

  hysteresis_thermostat_with_dwell uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result channel at random, one draw per cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Check every result request as it is taken. Everything read here was
  // driven by nonblocking assignment, so the values are those before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_event(out_data_o);
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic in_t mk_sample(bit ok, int t, logic [31:0] ms);
    in_t s;
    s.sample_ok    = ok;
    s.temperature  = clamp16(t);
    s.timestamp_ms = ms;
    return s;
  endfunction

  // Raise the write request and hold it until taken. Leave cfg_valid_i high:
  // the caller drops it after the last write, so it never falls and rises
  // within one step.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, d);
  endtask

  // Idle the sender at random, then present one sample and hold it until the
  // request is taken. Valid stays high for a back-to-back follower.
  task automatic send_sample(in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
  endtask

  // Drop the input, wait for every predicted event, then let silent samples
  // still inside the pipeline drain before anything else happens.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One random phase: fresh registers, then a run of samples shaped around
  // the control thresholds so that every branch gets exercised.
  task automatic run_phase(int unsigned p);
    int          sp;
    int          al;
    int          bw;
    int          span;
    int          t;
    int unsigned r;
    int unsigned bad_left;
    logic [31:0] ts;
    logic [31:0] step;
    logic [31:0] on_ms;
    logic [31:0] off_ms;
    logic [31:0] tmo;
    in_t         s;

    settle();
    case (p % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 69; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 69; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase

    // Push each register to an extreme in some phase; keep the rest moderate.
    if (p == 1) sp = -32768;
    else if (p == 2) sp = 32767;
    else sp = int'($urandom_range(4000)) - 2000;
    if (p == 3) bw = 0;
    else if (p == 4) bw = 32767;
    else if (p == 5) bw = 1;
    else bw = $urandom_range(200);
    if (p == 2) al = 32767;
    else if (p == 6) al = -32768;
    else al = sp + int'($urandom_range(400, 50));
    on_ms  = (p == 7) ? 32'hFFFF_FFFF : 32'($urandom_range(300));
    off_ms = (p == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(300));
    if (p == 3) tmo = 32'd0;
    else if (p == 5) tmo = 32'hFFFF_FFFF;
    else tmo = $urandom_range(1500, 50);

    // Load junk into the unused upper bits; the block must drop them.
    write_reg(REG_SETPOINT, {16'($urandom()), clamp16(sp)});
    write_reg(REG_HYST_BAND, {17'($urandom()), 15'(bw)});
    write_reg(REG_ALARM_HIGH, {16'($urandom()), clamp16(al)});
    write_reg(REG_MIN_ON, on_ms);
    write_reg(REG_MIN_OFF, off_ms);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(p[0] ? RegSpareHi : RegSpareLo, $urandom());
    cfg_valid_i <= 1'b0;

    sp = $signed(sb.setpoint);
    al = $signed(sb.alarm);
    bw = sb.band;
    ts = $urandom();
    bad_left = 0;
    for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
      // Invalid samples come in bursts, long enough at times to lose the sensor.
      if (bad_left == 0 && $urandom_range(99) < 10) bad_left = $urandom_range(8, 1);
      r = $urandom_range(99);
      if (r < 55) begin
        span = (bw >>> 1) + 20;
        t = sp + int'($urandom_range(2 * span)) - span;
      end else if (r < 72) begin
        t = al + int'($urandom_range(2 * bw + 20)) - (bw + 10);
      end else if (r < 85) begin
        t = al - bw + int'($urandom_range(10)) - 5;
      end else begin
        t = $signed(16'($urandom()));
      end
      r = $urandom_range(99);
      if (r < 78) step = $urandom_range(300);
      else if (r < 96) step = $urandom_range(3000);
      else step = $urandom();
      ts = ts + step;
      s = mk_sample(bad_left == 0, t, ts);
      if (bad_left > 0) bad_left--;
      send_sample(s);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at reset settings: no valid sample yet, both switch
    // directions at the band edges, temperature extremes, the latch and its
    // release, sensor loss with the heater on and off, recovery.
    send_sample(mk_sample(1'b0, 0, 32'd100));
    send_sample(mk_sample(1'b1, 320, 32'd200));
    send_sample(mk_sample(1'b1, 312, 32'd300));
    send_sample(mk_sample(1'b1, 327, 32'd400));
    send_sample(mk_sample(1'b1, 328, 32'd500));
    send_sample(mk_sample(1'b1, -32768, 32'd600));
    send_sample(mk_sample(1'b1, 32767, 32'd700));
    send_sample(mk_sample(1'b1, 1270, 32'd800));
    send_sample(mk_sample(1'b1, 1263, 32'd900));
    send_sample(mk_sample(1'b1, 0, 32'd1000));
    send_sample(mk_sample(1'b0, 0, 32'd5999));
    send_sample(mk_sample(1'b0, 0, 32'd6000));
    send_sample(mk_sample(1'b0, 0, 32'd7000));
    send_sample(mk_sample(1'b1, 100, 32'd7100));
    send_sample(mk_sample(1'b1, 400, 32'd7200));
    send_sample(mk_sample(1'b0, -1, 32'd12200));
    send_sample(mk_sample(1'b1, 2000, 32'd12300));
    send_sample(mk_sample(1'b1, 0, 32'hFFFF_FF00));

    // Zero timeout, dwell times across a timestamp wrap, dropped writes to
    // unused indexes and an over-wide setpoint write.
    settle();
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_MIN_ON, 32'd1000);
    write_reg(REG_MIN_OFF, 32'd1000);
    write_reg(RegSpareLo, 32'h0000_1234);
    write_reg(RegSpareHi, 32'hFFFF_FFFF);
    write_reg(REG_SETPOINT, 32'hABCD_0140);
    cfg_valid_i <= 1'b0;
    send_sample(mk_sample(1'b1, 400, 32'hFFFF_FF80));
    send_sample(mk_sample(1'b1, 400, 32'h0000_0300));
    send_sample(mk_sample(1'b1, 0, 32'h0000_0400));
    send_sample(mk_sample(1'b0, 0, 32'h0000_0401));
    send_sample(mk_sample(1'b1, 0, 32'h0000_0800));
    send_sample(mk_sample(1'b0, 0, 32'h0000_0801));

    for (int unsigned p = 0; p < NumPhases; p++) run_phase(p);

    settle();
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
